@@ hdl/gnv_pkg.sv @@
// Shared package of the vector normaliser: field widths, status codes,
// transaction payload structs and a width helper.
// No dependencies; every other file of the block refers to it by scoped name.
package gnv_pkg;

    localparam int VAL_W            = 64;
    localparam int STATUS_W         = 2;
    localparam int SHIFT_W          = $clog2(VAL_W);
    localparam int MAX_ELEMENTS_DEF = 16;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALL_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]    quotient;
        logic [VAL_W-1:0]    divisor;
        logic [STATUS_W-1:0] status;
        logic                final_res;
    } out_item_t;

    // Address width of a store with the given number of entries.
    function automatic int addr_w(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

@@ hdl/gnv_store.sv @@
// Element store of the vector normaliser: one write port, one registered read port.
// Depends on gnv_pkg.
module gnv_store #(
    parameter int DEPTH = gnv_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [gnv_pkg::addr_w(DEPTH)-1:0]   wr_addr,
    input  logic [gnv_pkg::VAL_W-1:0]           wr_data,
    input  logic                                rd_en,
    input  logic [gnv_pkg::addr_w(DEPTH)-1:0]   rd_addr,
    output logic [gnv_pkg::VAL_W-1:0]           rd_data
);

    logic [gnv_pkg::VAL_W-1:0] mem [DEPTH];
    logic [gnv_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/gnv_gcd.sv @@
// Iterative binary greatest-common-divisor unit, one reduction step per cycle.
// Depends on gnv_pkg.
module gnv_gcd (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gnv_pkg::VAL_W-1:0] a_in,
    input  logic [gnv_pkg::VAL_W-1:0] b_in,
    output logic                      done,
    output logic [gnv_pkg::VAL_W-1:0] result
);

    typedef enum logic [2:0] {
        G_IDLE    = 3'b001,
        G_REDUCE  = 3'b010,
        G_RESTORE = 3'b100
    } gcd_phase_t;

    gcd_phase_t                  phase_reg, phase_next;
    logic [gnv_pkg::VAL_W-1:0]   a_reg, a_next;
    logic [gnv_pkg::VAL_W-1:0]   b_reg, b_next;
    logic [gnv_pkg::SHIFT_W-1:0] k_reg, k_next;
    logic [gnv_pkg::VAL_W-1:0]   diff_ab;
    logic [gnv_pkg::VAL_W-1:0]   diff_ba;

    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;

    always_comb begin
        phase_next = phase_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        case (phase_reg)
            G_IDLE: begin
                if (start) begin
                    k_next = '0;
                    if (a_in == '0) begin
                        a_next     = b_in;
                        phase_next = G_RESTORE;
                    end else if (b_in == '0) begin
                        a_next     = a_in;
                        phase_next = G_RESTORE;
                    end else begin
                        a_next     = a_in;
                        b_next     = b_in;
                        phase_next = G_REDUCE;
                    end
                end
            end
            G_REDUCE: begin
                // Each step halves at least one operand, so the loop ends
                // within the combined bit length of both operands.
                if (a_reg == b_reg) begin
                    phase_next = G_RESTORE;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_reg > b_reg) begin
                    a_next = diff_ab >> 1;
                end else begin
                    b_next = diff_ba >> 1;
                end
            end
            G_RESTORE: begin
                // Put back the common factors of two, one bit a cycle.
                if (k_reg == '0) begin
                    phase_next = G_IDLE;
                end else begin
                    a_next = a_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            default: begin
                phase_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= G_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign done   = (phase_reg == G_RESTORE) && (k_reg == '0);
    assign result = a_reg;

endmodule

@@ hdl/gnv_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, most significant first.
// Depends on gnv_pkg.
module gnv_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gnv_pkg::VAL_W-1:0] dividend,
    input  logic [gnv_pkg::VAL_W-1:0] denom,
    output logic                      done,
    output logic [gnv_pkg::VAL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(gnv_pkg::VAL_W) + 1;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [gnv_pkg::VAL_W-1:0] rem_reg, rem_next;
    logic [gnv_pkg::VAL_W-1:0] quo_reg, quo_next;
    logic [gnv_pkg::VAL_W-1:0] den_reg, den_next;
    logic [gnv_pkg::VAL_W:0]   trial;

    // Partial remainder with the next dividend bit brought down, less the divisor.
    assign trial = {rem_reg, quo_reg[gnv_pkg::VAL_W-1]} - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (busy_reg) begin
            if (trial[gnv_pkg::VAL_W]) begin
                rem_next = {rem_reg[gnv_pkg::VAL_W-2:0], quo_reg[gnv_pkg::VAL_W-1]};
                quo_next = {quo_reg[gnv_pkg::VAL_W-2:0], 1'b0};
            end else begin
                rem_next = trial[gnv_pkg::VAL_W-1:0];
                quo_next = {quo_reg[gnv_pkg::VAL_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gnv_pkg::VAL_W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = denom;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/gcd_normalize_vector.sv @@
// Top level of the vector normaliser: control sequencer, output register and run state.
// Depends on gnv_pkg, gnv_store, gnv_gcd and gnv_div.
//
// The block takes one unsigned 64-bit element per input transaction, with last
// marking the final element of a vector, and works on one transaction at a time.
// Each element is written to the element store (up to MAX_ELEMENTS of them) and
// folded into a running greatest common divisor by a binary GCD unit that makes
// one reduction step a cycle, at most one step per bit of the two operands, and
// then restores one by one the common factors of two it took out. After the last
// element the block emits one result transaction per stored element, in arrival
// order, each being the element divided by the common divisor; for each result
// the store is read and a bit-serial divider is loaded, which then gives one
// quotient bit a cycle until the full 64-bit quotient is formed. Only the
// last result of a run carries final_res. If more elements arrived than the store
// holds, a single result with status 2 (too many) and the divisor of all elements
// is given instead; if every element was zero, a single result with status 1 and
// a zero divisor. The store needs no clearing after reset: each run only reads the
// entries it has written. A result waits in an output register until taken, and
// no new element is taken while it waits.
module gcd_normalize_vector #(
    parameter int MAX_ELEMENTS = gnv_pkg::MAX_ELEMENTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gnv_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gnv_pkg::out_item_t m_data
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W = gnv_pkg::addr_w(MAX_ELEMENTS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_GCD  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [gnv_pkg::VAL_W-1:0] gcd_reg, gcd_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      ovf_reg, ovf_next;
    logic                      last_reg, last_next;
    logic                      end_reg, end_next;
    gnv_pkg::out_item_t        out_reg, out_next;

    logic                      s_accept;
    logic                      m_accept;
    logic                      room;
    logic                      gcd_done;
    logic [gnv_pkg::VAL_W-1:0] gcd_result;
    logic                      rd_en;
    logic [gnv_pkg::VAL_W-1:0] rd_data;
    logic                      div_start;
    logic                      div_done;
    logic [gnv_pkg::VAL_W-1:0] div_quo;
    logic [CNT_W-1:0]          idx_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign m_data   = out_reg;
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;
    assign room     = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign rd_en    = (state_reg == ST_RD);
    assign div_start = (state_reg == ST_LOAD);
    assign idx_inc  = idx_reg + 1'b1;

    gnv_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept && room),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_data.value),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    gnv_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .a_in    (gcd_reg),
        .b_in    (s_data.value),
        .done    (gcd_done),
        .result  (gcd_result)
    );

    gnv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_data),
        .denom    (gcd_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        gcd_next   = gcd_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        out_next   = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Elements beyond the store's depth are dropped but still
                    // count towards the divisor.
                    if (room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    last_next  = s_data.last;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_done) begin
                    gcd_next = gcd_result;
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (ovf_reg) begin
                        out_next.quotient  = '0;
                        out_next.divisor   = gcd_result;
                        out_next.status    = gnv_pkg::STATUS_TOO_MANY;
                        out_next.final_res = 1'b1;
                        end_next           = 1'b1;
                        state_next         = ST_OUT;
                    end else if (gcd_result == '0) begin
                        out_next.quotient  = '0;
                        out_next.divisor   = '0;
                        out_next.status    = gnv_pkg::STATUS_ALL_ZERO;
                        out_next.final_res = 1'b1;
                        end_next           = 1'b1;
                        state_next         = ST_OUT;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    out_next.quotient  = div_quo;
                    out_next.divisor   = gcd_reg;
                    out_next.status    = gnv_pkg::STATUS_OK;
                    out_next.final_res = (idx_inc == count_reg);
                    end_next           = (idx_inc == count_reg);
                    state_next         = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_accept) begin
                    if (end_reg) begin
                        // Run complete: clear the run state for the next vector.
                        gcd_next   = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        end_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gcd_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            gcd_reg   <= gcd_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule
